@@ rtl/ipat_pkg.sv @@
// Shared types, character codes and digit helpers for the address-to-text block.
package ipat_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INVALID,
    S_DEC,
    S_V4_DOT,
    S_V6_OPEN,
    S_V6_GRP,
    S_V6_DC1,
    S_V6_DC2,
    S_V6_HEX,
    S_V6_CLOSE,
    S_COLON
  } state_t;

  localparam logic [1:0] FAM_IPV4 = 2'd1;
  localparam logic [1:0] FAM_IPV6 = 2'd2;

  localparam logic [15:0] DIV_10000 = 16'd10000;
  localparam logic [15:0] DIV_1000  = 16'd1000;
  localparam logic [15:0] DIV_100   = 16'd100;
  localparam logic [15:0] DIV_10    = 16'd10;

  localparam logic [2:0] POS_10000 = 3'd0;
  localparam logic [2:0] POS_1000  = 3'd1;
  localparam logic [2:0] POS_100   = 3'd2;
  localparam logic [2:0] POS_10    = 3'd3;
  localparam logic [2:0] POS_ONES  = 3'd4;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOWA   = 8'h61;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_OPEN   = 8'h5b;
  localparam logic [7:0] CH_CLOSE  = 8'h5d;
  localparam logic [7:0] CH_NUL    = 8'h00;

  function automatic logic [15:0] dec_div(input logic [2:0] pos);
    logic [15:0] d;
    case (pos)
      POS_10000: d = DIV_10000;
      POS_1000:  d = DIV_1000;
      POS_100:   d = DIV_100;
      default:   d = DIV_10;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_LOWA + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

@@ rtl/ip_address_to_text_core.sv @@
// Top level: converts an IPv4 or IPv6 address and optional port into URI host text.
//
// An address beat is taken on the input channel (in_valid/in_ready) and the text
// leaves on the output channel (out_valid/out_ready), one ASCII character per beat,
// with last set on the final character. An unknown family yields a single beat with
// invalid and last set and a zero character.
// One sequencer and one shared compare-and-subtract unit do the work. in_ready is
// high only while the sequencer is idle; one address is handled at a time.
// For IPv4 the first digit needs its subtractions before the first character is
// registered. The sequencer handles in turn each emitted character, each suppressed
// leading zero nibble or decimal place, each group start that writes no colon, and
// each subtraction of a place value (at most nine per digit).
// A single output register holds the current character; while the receiver stalls,
// the sequencer waits, and the next address may be accepted while the final
// character of the previous one is still held.
// Reset returns the sequencer to idle and empties the output register.
module ip_address_to_text_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  family,
  input  logic [63:0] addr_high,
  input  logic [63:0] addr_low,
  input  logic [15:0] port,
  input  logic        with_port,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  text_char,
  output logic        last,
  output logic        invalid
);

  ipat_pkg::state_t state, state_next;

  logic [127:0] addr, addr_next;
  logic [15:0]  port_r, port_r_next;
  logic         with_port_r, with_port_r_next;
  logic [15:0]  dec_val, dec_val_next;
  logic [3:0]   digit, digit_next;
  logic [2:0]   dec_pos, dec_pos_next;
  logic         shown, shown_next;
  logic         dec_port, dec_port_next;
  logic [1:0]   oct_idx, oct_idx_next;
  logic [2:0]   grp_idx, grp_idx_next;
  logic [1:0]   nib, nib_next;

  logic         emit_req;
  logic [7:0]   emit_char;
  logic         emit_last;
  logic         emit_inv;
  logic         slot_free;
  logic         advance;

  logic [15:0]  div;
  logic         ge;
  logic [7:0]   octet;
  logic [15:0]  grp;
  logic [3:0]   nib_val;
  logic [7:0]   zero_grp;
  logic         run_found;
  logic [2:0]   run_start;
  logic [3:0]   run_end;
  logic         need_colon;

  assign in_ready  = (state == ipat_pkg::S_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign advance   = !emit_req || slot_free;

  assign div     = ipat_pkg::dec_div(dec_pos);
  assign ge      = (dec_val >= div);
  assign octet   = 8'(addr[31:0] >> {2'd2 - oct_idx, 3'b000});
  assign grp     = 16'(addr >> {~grp_idx, 4'b0000});
  assign nib_val = 4'(grp >> {nib, 2'b00});

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      zero_grp[i] = (addr[(7 - i) * 16 +: 16] == 16'd0);
    end
    run_found = 1'b0;
    run_start = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (!run_found && zero_grp[i] && zero_grp[i + 1]) begin
        run_found = 1'b1;
        run_start = 3'(i);
      end
    end
    run_end = 4'd8;
    for (int j = 7; j >= 0; j--) begin
      if (3'(j) > run_start && !zero_grp[j]) begin
        run_end = 4'(j);
      end
    end
  end

  assign need_colon = (grp_idx != 3'd0) && !(run_found && ({1'b0, grp_idx} == run_end));

  always_comb begin
    state_next       = state;
    addr_next        = addr;
    port_r_next      = port_r;
    with_port_r_next = with_port_r;
    dec_val_next     = dec_val;
    digit_next       = digit;
    dec_pos_next     = dec_pos;
    shown_next       = shown;
    dec_port_next    = dec_port;
    oct_idx_next     = oct_idx;
    grp_idx_next     = grp_idx;
    nib_next         = nib;
    emit_req         = 1'b0;
    emit_char        = ipat_pkg::CH_NUL;
    emit_last        = 1'b0;
    emit_inv         = 1'b0;

    unique case (state)
      ipat_pkg::S_IDLE: begin
        if (in_valid) begin
          addr_next        = {addr_high, addr_low};
          port_r_next      = port;
          with_port_r_next = with_port;
          dec_val_next     = {8'd0, addr_low[31:24]};
          digit_next       = 4'd0;
          dec_pos_next     = ipat_pkg::POS_100;
          shown_next       = 1'b0;
          dec_port_next    = 1'b0;
          oct_idx_next     = 2'd0;
          grp_idx_next     = 3'd0;
          if (family == ipat_pkg::FAM_IPV4) begin
            state_next = ipat_pkg::S_DEC;
          end else if (family == ipat_pkg::FAM_IPV6) begin
            state_next = ipat_pkg::S_V6_OPEN;
          end else begin
            state_next = ipat_pkg::S_INVALID;
          end
        end
      end
      ipat_pkg::S_INVALID: begin
        emit_req  = 1'b1;
        emit_last = 1'b1;
        emit_inv  = 1'b1;
        if (advance) begin
          state_next = ipat_pkg::S_IDLE;
        end
      end
      ipat_pkg::S_DEC: begin
        if (dec_pos != ipat_pkg::POS_ONES) begin
          if (ge) begin
            dec_val_next = dec_val - div;
            digit_next   = digit + 4'd1;
          end else begin
            emit_req  = (digit != 4'd0) || shown;
            emit_char = ipat_pkg::CH_ZERO + {4'd0, digit};
            if (advance) begin
              shown_next   = shown || (digit != 4'd0);
              digit_next   = 4'd0;
              dec_pos_next = dec_pos + 3'd1;
            end
          end
        end else begin
          emit_req  = 1'b1;
          emit_char = ipat_pkg::CH_ZERO + {4'd0, dec_val[3:0]};
          emit_last = dec_port || ((oct_idx == 2'd3) && !with_port_r);
          if (advance) begin
            if (dec_port) begin
              state_next = ipat_pkg::S_IDLE;
            end else if (oct_idx == 2'd3) begin
              state_next = with_port_r ? ipat_pkg::S_COLON : ipat_pkg::S_IDLE;
            end else begin
              state_next = ipat_pkg::S_V4_DOT;
            end
          end
        end
      end
      ipat_pkg::S_V4_DOT: begin
        emit_req  = 1'b1;
        emit_char = ipat_pkg::CH_DOT;
        if (advance) begin
          oct_idx_next = oct_idx + 2'd1;
          dec_val_next = {8'd0, octet};
          digit_next   = 4'd0;
          dec_pos_next = ipat_pkg::POS_100;
          shown_next   = 1'b0;
          state_next   = ipat_pkg::S_DEC;
        end
      end
      ipat_pkg::S_V6_OPEN: begin
        emit_req  = 1'b1;
        emit_char = ipat_pkg::CH_OPEN;
        if (advance) begin
          state_next = ipat_pkg::S_V6_GRP;
        end
      end
      ipat_pkg::S_V6_GRP: begin
        if (run_found && (grp_idx == run_start)) begin
          state_next = ipat_pkg::S_V6_DC1;
        end else begin
          emit_req  = need_colon;
          emit_char = ipat_pkg::CH_COLON;
          if (advance) begin
            nib_next   = 2'd3;
            shown_next = 1'b0;
            state_next = ipat_pkg::S_V6_HEX;
          end
        end
      end
      ipat_pkg::S_V6_DC1: begin
        emit_req  = 1'b1;
        emit_char = ipat_pkg::CH_COLON;
        if (advance) begin
          state_next = ipat_pkg::S_V6_DC2;
        end
      end
      ipat_pkg::S_V6_DC2: begin
        emit_req  = 1'b1;
        emit_char = ipat_pkg::CH_COLON;
        if (advance) begin
          if (run_end == 4'd8) begin
            state_next = ipat_pkg::S_V6_CLOSE;
          end else begin
            grp_idx_next = run_end[2:0];
            nib_next     = 2'd3;
            shown_next   = 1'b0;
            state_next   = ipat_pkg::S_V6_HEX;
          end
        end
      end
      ipat_pkg::S_V6_HEX: begin
        emit_char = ipat_pkg::hex_char(nib_val);
        if (nib != 2'd0) begin
          emit_req = (nib_val != 4'd0) || shown;
          if (advance) begin
            shown_next = shown || (nib_val != 4'd0);
            nib_next   = nib - 2'd1;
          end
        end else begin
          emit_req = 1'b1;
          if (advance) begin
            if (grp_idx == 3'd7) begin
              state_next = ipat_pkg::S_V6_CLOSE;
            end else begin
              grp_idx_next = grp_idx + 3'd1;
              state_next   = ipat_pkg::S_V6_GRP;
            end
          end
        end
      end
      ipat_pkg::S_V6_CLOSE: begin
        emit_req  = 1'b1;
        emit_char = ipat_pkg::CH_CLOSE;
        emit_last = !with_port_r;
        if (advance) begin
          state_next = with_port_r ? ipat_pkg::S_COLON : ipat_pkg::S_IDLE;
        end
      end
      ipat_pkg::S_COLON: begin
        emit_req  = 1'b1;
        emit_char = ipat_pkg::CH_COLON;
        if (advance) begin
          dec_val_next  = port_r;
          digit_next    = 4'd0;
          dec_pos_next  = ipat_pkg::POS_10000;
          shown_next    = 1'b0;
          dec_port_next = 1'b1;
          state_next    = ipat_pkg::S_DEC;
        end
      end
      default: begin
        state_next = ipat_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ipat_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_req && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr        <= addr_next;
    port_r      <= port_r_next;
    with_port_r <= with_port_r_next;
    dec_val     <= dec_val_next;
    digit       <= digit_next;
    dec_pos     <= dec_pos_next;
    shown       <= shown_next;
    dec_port    <= dec_port_next;
    oct_idx     <= oct_idx_next;
    grp_idx     <= grp_idx_next;
    nib         <= nib_next;
    if (emit_req && slot_free) begin
      text_char <= emit_char;
      last      <= emit_last;
      invalid   <= emit_inv;
    end
  end

endmodule

@@ rtl/ipat_checker.sv @@
// Port-level checker for the address-to-text block, with its bind statement.
module ipat_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] text_char,
  input logic       last,
  input logic       invalid
);

  // An invalid beat is a lone, final, zero character.
  a_invalid_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid |-> last && (text_char == 8'h00))
    else $error("invalid beat is not a final zero character");

  // Once an address is taken, no further one is taken in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while the previous address is in work");

  // Every valid character lies in the set used by address text.
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !invalid |-> (text_char >= 8'h2e) && (text_char <= 8'h66))
    else $error("character outside the address text set");

  // A stalled beat holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(text_char) && $stable(last)
      && $stable(invalid))
    else $error("stalled output beat changed");

endmodule

bind ip_address_to_text_core ipat_checker u_ipat_checker (.*);

@@ verif/ip_address_to_text_core_tb.sv @@
// Testbench for ip_address_to_text_core: directed and random addresses checked beat by beat.
module ip_address_to_text_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FAM_UNKNOWN  = 2'd0;
  localparam logic [1:0] FAM_RESERVED = 2'd3;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       invalid;
  } text_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  family = '0;
  logic [63:0] addr_high = '0;
  logic [63:0] addr_low = '0;
  logic [15:0] port = '0;
  logic        with_port = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  text_char;
  logic        last;
  logic        invalid;

  text_beat_t  text_q[$];
  logic [7:0]  text_buf[$];
  string       hex_digits = "0123456789abcdef";

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int items_sent = 0;
  int beats_checked = 0;
  int error_count = 0;
  int cycle_count = 0;

  ip_address_to_text_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .family    (family),
    .addr_high (addr_high),
    .addr_low  (addr_low),
    .port      (port),
    .with_port (with_port),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .text_char (text_char),
    .last      (last),
    .invalid   (invalid)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d beats outstanding", $time, text_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : text_checker
    text_beat_t want;
    if (!rst && out_valid && out_ready) begin
      beats_checked++;
      if (text_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got char %0h last %0b invalid %0b",
                 $time, text_char, last, invalid);
        error_count++;
      end else begin
        want = text_q.pop_front();
        check_field("text_char", want.ch, text_char);
        check_field("last", want.last, last);
        check_field("invalid", want.invalid, invalid);
      end
    end
  end

  function automatic void add_decimal(input int unsigned v);
    int unsigned div;
    int unsigned d;
    bit shown;
    shown = 1'b0;
    div = 10000;
    while (div > 1) begin
      d = v / div;
      v = v % div;
      if (d != 0) shown = 1'b1;
      if (shown) text_buf.push_back(ipat_pkg::CH_ZERO + 8'(d));
      div = div / 10;
    end
    text_buf.push_back(ipat_pkg::CH_ZERO + 8'(v));
  endfunction

  function automatic void add_group(input logic [15:0] g);
    int sh;
    logic [3:0] nib;
    bit shown;
    shown = 1'b0;
    for (sh = 12; sh > 0; sh -= 4) begin
      nib = g[sh +: 4];
      if (nib != 0) shown = 1'b1;
      if (shown) text_buf.push_back(hex_digits[nib]);
    end
    text_buf.push_back(hex_digits[g[3:0]]);
  endfunction

  function automatic void predict_text(input logic [1:0] fam, input logic [63:0] hi,
                                       input logic [63:0] lo, input logic [15:0] prt,
                                       input logic wp);
    logic [127:0] addr;
    logic [15:0] grp [8];
    int run_at;
    int run_len;
    int i;
    int j;
    addr = {hi, lo};
    run_at = -1;
    run_len = 0;
    text_buf.delete();
    if (fam == ipat_pkg::FAM_IPV4) begin
      for (i = 0; i < 4; i++) begin
        if (i != 0) text_buf.push_back(ipat_pkg::CH_DOT);
        add_decimal(lo[8*(3-i) +: 8]);
      end
    end else if (fam == ipat_pkg::FAM_IPV6) begin
      for (i = 0; i < 8; i++) grp[i] = addr[16*(7-i) +: 16];
      // Only the first run of two or more zero groups is compressed.
      for (i = 0; i < 7 && run_at < 0; i++) begin
        if (grp[i] == 0 && grp[i+1] == 0) begin
          run_at = i;
          j = i;
          while (j < 8 && grp[j] == 0) j++;
          run_len = j - i;
        end
      end
      text_buf.push_back(ipat_pkg::CH_OPEN);
      i = 0;
      while (i < 8) begin
        if (i == run_at) begin
          text_buf.push_back(ipat_pkg::CH_COLON);
          text_buf.push_back(ipat_pkg::CH_COLON);
          i += run_len;
        end else begin
          if (i != 0 && i != run_at + run_len) text_buf.push_back(ipat_pkg::CH_COLON);
          add_group(grp[i]);
          i++;
        end
      end
      text_buf.push_back(ipat_pkg::CH_CLOSE);
    end else begin
      text_q.push_back('{ch: ipat_pkg::CH_NUL, last: 1'b1, invalid: 1'b1});
      return;
    end
    if (wp) begin
      text_buf.push_back(ipat_pkg::CH_COLON);
      add_decimal(prt);
    end
    for (i = 0; i < text_buf.size(); i++) begin
      text_q.push_back('{ch: text_buf[i], last: (i == text_buf.size() - 1), invalid: 1'b0});
    end
  endfunction

  function automatic logic [7:0] rand_octet();
    case ($urandom_range(2))
      0:       return 8'($urandom_range(9));
      1:       return 8'($urandom_range(99));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [15:0] rand_port();
    case ($urandom_range(4))
      0:       return 16'($urandom_range(9));
      1:       return 16'($urandom_range(99));
      2:       return 16'($urandom_range(999));
      3:       return 16'($urandom_range(9999));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [127:0] rand_v6();
    logic [127:0] a;
    int k;
    int r;
    for (k = 0; k < 8; k++) begin
      r = $urandom_range(9);
      if (r < 4) a[16*k +: 16] = 16'h0;
      else if (r < 6) a[16*k +: 16] = 16'($urandom_range(255));
      else a[16*k +: 16] = 16'($urandom_range(65535));
    end
    return a;
  endfunction

  task automatic send_address(input logic [1:0] fam, input logic [63:0] hi,
                              input logic [63:0] lo, input logic [15:0] prt,
                              input logic wp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    family    <= fam;
    addr_high <= hi;
    addr_low  <= lo;
    port      <= prt;
    with_port <= wp;
    do @(posedge clk); while (!in_ready);
    predict_text(fam, hi, lo, prt, wp);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic test_ipv4_text();
    send_address(ipat_pkg::FAM_IPV4, 64'h0, 64'h0, 16'd0, 1'b0);
    send_address(ipat_pkg::FAM_IPV4, '1, '1, 16'd65535, 1'b1);
    send_address(ipat_pkg::FAM_IPV4, 64'h0123_4567_89ab_cdef, 64'hdead_beef_0a64_c809,
                 16'd0, 1'b1);
    send_address(ipat_pkg::FAM_IPV4, 64'h0, 64'h0000_0000_0102_0304, 16'd10000, 1'b0);
    send_address(ipat_pkg::FAM_IPV4, 64'h0, 64'h0000_0000_c0a8_010a, 16'd10000, 1'b1);
  endtask

  task automatic test_ipv6_text();
    send_address(ipat_pkg::FAM_IPV6, 64'h0, 64'h0, 16'd0, 1'b0);
    send_address(ipat_pkg::FAM_IPV6, 64'h0, 64'h0, 16'd1, 1'b1);
    send_address(ipat_pkg::FAM_IPV6, '1, '1, 16'd65535, 1'b1);
    send_address(ipat_pkg::FAM_IPV6, 64'h2001_0db8_0000_0000, 64'h0, 16'd443, 1'b1);
    send_address(ipat_pkg::FAM_IPV6, 64'h0, 64'h0000_0000_0000_0001, 16'd0, 1'b0);
    send_address(ipat_pkg::FAM_IPV6, 64'h0001_0000_0002_0003, 64'h0004_0005_0006_0007,
                 16'd80, 1'b0);
    send_address(ipat_pkg::FAM_IPV6, 64'h0001_0000_0000_0002, 64'h0000_0000_0000_0003,
                 16'd9, 1'b1);
    send_address(ipat_pkg::FAM_IPV6, 64'h0abc_00f0_000a_1000, 64'hfedc_ba98_7654_3210,
                 16'd8080, 1'b1);
    send_address(ipat_pkg::FAM_IPV6, 64'h0001_0002_0000_0000, 64'h0000_0000_0007_0008,
                 16'd0, 1'b0);
    send_address(ipat_pkg::FAM_IPV6, 64'h0001_0002_0003_0004, 64'h0005_0006_0007_0000,
                 16'd0, 1'b0);
  endtask

  task automatic test_unknown_family();
    send_address(FAM_UNKNOWN, {$urandom, $urandom}, {$urandom, $urandom}, 16'd1234, 1'b1);
    send_address(FAM_RESERVED, '1, '1, 16'd65535, 1'b1);
  endtask

  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    logic [127:0] v6;
    logic [63:0] lo;
    int pick;
    int k;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(19);
      if (pick < 9) begin
        lo = {32'($urandom), rand_octet(), rand_octet(), rand_octet(), rand_octet()};
        send_address(ipat_pkg::FAM_IPV4, {$urandom, $urandom}, lo, rand_port(),
                     1'($urandom_range(1)));
      end else if (pick < 18) begin
        v6 = rand_v6();
        send_address(ipat_pkg::FAM_IPV6, v6[127:64], v6[63:0], rand_port(),
                     1'($urandom_range(1)));
      end else begin
        send_address((pick == 18) ? FAM_UNKNOWN : FAM_RESERVED, {$urandom, $urandom},
                     {$urandom, $urandom}, 16'($urandom), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_output_hold();
    logic [127:0] v6;
    int k;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = HOLD_CYCLES;
    for (k = 0; k < 6; k++) begin
      v6 = rand_v6();
      if (k[0]) send_address(ipat_pkg::FAM_IPV6, v6[127:64], v6[63:0], rand_port(), 1'b1);
      else send_address(ipat_pkg::FAM_IPV4, 64'h0, v6[63:0], rand_port(), 1'b1);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_ipv4_text();
    test_ipv6_text();
    test_unknown_family();
    test_random_traffic(37, 0, 0);
    test_random_traffic(37, 57, 0);
    test_random_traffic(37, 0, 57);
    test_random_traffic(37, 15, 15);
    test_output_hold();
    in_valid <= 1'b0;
    while (text_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (text_q.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, text_q.size());
      error_count++;
    end
    $display("Run covered %0d addresses (IPv4, IPv6 with zero-run compression, unknown)",
             items_sent);
    $display("and %0d beats under idle and stall mixes plus a long hold-off; %0d mismatches.",
             beats_checked, error_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ipat_pkg.sv
rtl/ip_address_to_text_core.sv
rtl/ipat_checker.sv
verif/ip_address_to_text_core_tb.sv
